// ----- hdl/rth_pkg.sv -----
package rth_pkg;

    localparam int unsigned CHAN_PORT_BITS = 16;
    localparam int unsigned HUE_BITS       = 9;
    localparam int unsigned SAT_BITS       = 7;
    localparam int unsigned QUO_BITS       = 9;
    localparam int unsigned HUE_WRAP       = 360;
    localparam int unsigned SAT_FULL       = 100;

    typedef enum logic [1:0] {
        SEC_RED   = 2'd0,
        SEC_GREEN = 2'd1,
        SEC_BLUE  = 2'd2
    } t_sector;

    typedef struct packed {
        logic [CHAN_PORT_BITS-1:0] red;
        logic [CHAN_PORT_BITS-1:0] green;
        logic [CHAN_PORT_BITS-1:0] blue;
    } t_rgb;

    typedef struct packed {
        logic [HUE_BITS-1:0]       hue;
        logic [SAT_BITS-1:0]       saturation;
        logic [CHAN_PORT_BITS-1:0] brightness;
    } t_hsv;

endpackage

// ----- hdl/rth_front.sv -----
module rth_front #(
    parameter int unsigned CHANNEL_BITS = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    input  rth_pkg::t_rgb                        i_pixel,
    output logic                                 o_valid,
    output logic [CHANNEL_BITS+rth_pkg::QUO_BITS-1:0] o_hue_num,
    output logic [CHANNEL_BITS-1:0]              o_hue_div,
    output logic [CHANNEL_BITS+rth_pkg::QUO_BITS-1:0] o_sat_num,
    output logic [CHANNEL_BITS-1:0]              o_sat_div,
    output logic [CHANNEL_BITS-1:0]              o_bright
);
    import rth_pkg::*;

    localparam int unsigned CB = CHANNEL_BITS;
    localparam int unsigned W  = CB + QUO_BITS;
    localparam int unsigned SW = CB + 11;

    logic [CB-1:0] r, g, b;
    logic [CB-1:0] mx, mn;
    logic signed [CB:0] d;
    t_sector sec;
    logic grey;

    logic              r_valid_a, r_grey;
    logic [CB-1:0]     r_mx, r_rng;
    logic signed [CB:0] r_d;
    t_sector           r_sec;

    logic [CB+2:0]       off_rng;
    logic signed [SW-1:0] s_base, s_num, s_wrap, s_fix;
    logic [W-1:0]        sat_num;

    logic          r_valid_b;
    logic [W-1:0]  r_hnum, r_snum;
    logic [CB-1:0] r_hdiv, r_sdiv, r_bright;

    assign r = i_pixel.red[CB-1:0];
    assign g = i_pixel.green[CB-1:0];
    assign b = i_pixel.blue[CB-1:0];

    always_comb begin
        grey = (r == g) && (r == b);
        if (grey || ((r >= g) && (r >= b))) begin
            mx  = r;
            mn  = (g < b) ? g : b;
            d   = $signed({1'b0, g}) - $signed({1'b0, b});
            sec = SEC_RED;
        end else if ((g >= r) && (g >= b)) begin
            mx  = g;
            mn  = (r < b) ? r : b;
            d   = $signed({1'b0, b}) - $signed({1'b0, r});
            sec = SEC_GREEN;
        end else begin
            mx  = b;
            mn  = (r < g) ? r : g;
            d   = $signed({1'b0, r}) - $signed({1'b0, g});
            sec = SEC_BLUE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_a <= 1'b0;
        end else begin
            r_valid_a <= i_valid;
        end
        r_grey <= grey;
        r_mx   <= mx;
        r_rng  <= mx - mn;
        r_d    <= d;
        r_sec  <= sec;
    end

    always_comb begin
        case (r_sec)
            SEC_RED:   off_rng = '0;
            SEC_GREEN: off_rng = {2'b00, r_rng, 1'b0};
            SEC_BLUE:  off_rng = {1'b0, r_rng, 2'b00};
            default:   off_rng = '0;
        endcase
        s_base  = $signed(SW'(off_rng)) + $signed({{(SW-CB-1){r_d[CB]}}, r_d});
        s_num   = (s_base <<< 6) - (s_base <<< 2);
        s_wrap  = $signed((SW'(r_rng) << 8) + (SW'(r_rng) << 6)
                          + (SW'(r_rng) << 5) + (SW'(r_rng) << 3));
        s_fix   = s_num[SW-1] ? (s_num + s_wrap) : s_num;
        sat_num = (W'(r_rng) << 6) + (W'(r_rng) << 5) + (W'(r_rng) << 2);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_b <= 1'b0;
        end else begin
            r_valid_b <= r_valid_a;
        end
        r_bright <= r_mx;
        if (r_grey) begin
            r_hnum <= '0;
            r_snum <= '0;
            r_hdiv <= '1;
            r_sdiv <= '1;
        end else begin
            r_hnum <= s_fix[W-1:0];
            r_snum <= sat_num;
            r_hdiv <= r_rng;
            r_sdiv <= r_mx;
        end
    end

    assign o_valid   = r_valid_b;
    assign o_hue_num = r_hnum;
    assign o_hue_div = r_hdiv;
    assign o_sat_num = r_snum;
    assign o_sat_div = r_sdiv;
    assign o_bright  = r_bright;

endmodule

// ----- hdl/rth_div_cell.sv -----
module rth_div_cell #(
    parameter int unsigned CHANNEL_BITS = 16,
    parameter int unsigned BIT_POS      = 0
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_valid,
    input  logic [CHANNEL_BITS+rth_pkg::QUO_BITS-1:0] i_hue_rem,
    input  logic [CHANNEL_BITS-1:0]                   i_hue_div,
    input  logic [rth_pkg::QUO_BITS-1:0]              i_hue_quo,
    input  logic [CHANNEL_BITS+rth_pkg::QUO_BITS-1:0] i_sat_rem,
    input  logic [CHANNEL_BITS-1:0]                   i_sat_div,
    input  logic [rth_pkg::QUO_BITS-1:0]              i_sat_quo,
    input  logic [CHANNEL_BITS-1:0]                   i_bright,
    output logic                                      o_valid,
    output logic [CHANNEL_BITS+rth_pkg::QUO_BITS-1:0] o_hue_rem,
    output logic [CHANNEL_BITS-1:0]                   o_hue_div,
    output logic [rth_pkg::QUO_BITS-1:0]              o_hue_quo,
    output logic [CHANNEL_BITS+rth_pkg::QUO_BITS-1:0] o_sat_rem,
    output logic [CHANNEL_BITS-1:0]                   o_sat_div,
    output logic [rth_pkg::QUO_BITS-1:0]              o_sat_quo,
    output logic [CHANNEL_BITS-1:0]                   o_bright
);
    import rth_pkg::*;

    localparam int unsigned W = CHANNEL_BITS + QUO_BITS;

    logic [W-1:0] hue_sh, sat_sh;
    logic         hue_ge, sat_ge;
    logic [W-1:0] n_hue_rem, n_sat_rem;
    logic [QUO_BITS-1:0] n_hue_quo, n_sat_quo;

    logic                r_valid;
    logic [W-1:0]        r_hue_rem, r_sat_rem;
    logic [CHANNEL_BITS-1:0] r_hue_div, r_sat_div, r_bright;
    logic [QUO_BITS-1:0] r_hue_quo, r_sat_quo;

    always_comb begin
        hue_sh    = W'(i_hue_div) << BIT_POS;
        sat_sh    = W'(i_sat_div) << BIT_POS;
        hue_ge    = i_hue_rem >= hue_sh;
        sat_ge    = i_sat_rem >= sat_sh;
        n_hue_rem = hue_ge ? (i_hue_rem - hue_sh) : i_hue_rem;
        n_sat_rem = sat_ge ? (i_sat_rem - sat_sh) : i_sat_rem;
        n_hue_quo = i_hue_quo;
        n_sat_quo = i_sat_quo;
        n_hue_quo[BIT_POS] = hue_ge;
        n_sat_quo[BIT_POS] = sat_ge;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_hue_rem <= n_hue_rem;
        r_sat_rem <= n_sat_rem;
        r_hue_div <= i_hue_div;
        r_sat_div <= i_sat_div;
        r_hue_quo <= n_hue_quo;
        r_sat_quo <= n_sat_quo;
        r_bright  <= i_bright;
    end

    assign o_valid   = r_valid;
    assign o_hue_rem = r_hue_rem;
    assign o_hue_div = r_hue_div;
    assign o_hue_quo = r_hue_quo;
    assign o_sat_rem = r_sat_rem;
    assign o_sat_div = r_sat_div;
    assign o_sat_quo = r_sat_quo;
    assign o_bright  = r_bright;

endmodule

// ----- hdl/rgb_to_hsv.sv -----
// Channel   Direction  Ports                Payload
// command   in         start, busy          i_pixel (red, green, blue)
// result    out        o_valid              o_result (hue, saturation, brightness)
//
// One item is taken in every cycle; busy is always low.
// Each result passes through two front stages, which find the
// largest channel and form the numerators, then through nine divider cells
// that each settle one quotient bit of hue and of saturation.
// Reset clears only the valid flags of the stages.
// The results are never held back, so nothing in the chain ever stalls.
module rgb_to_hsv #(
    parameter int unsigned CHANNEL_BITS = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  rth_pkg::t_rgb   i_pixel,
    output logic            o_valid,
    output rth_pkg::t_hsv   o_result
);
    import rth_pkg::*;

    localparam int unsigned W = CHANNEL_BITS + QUO_BITS;

    logic                    vld     [0:QUO_BITS];
    logic [W-1:0]            hue_rem [0:QUO_BITS];
    logic [CHANNEL_BITS-1:0] hue_div [0:QUO_BITS];
    logic [QUO_BITS-1:0]     hue_quo [0:QUO_BITS];
    logic [W-1:0]            sat_rem [0:QUO_BITS];
    logic [CHANNEL_BITS-1:0] sat_div [0:QUO_BITS];
    logic [QUO_BITS-1:0]     sat_quo [0:QUO_BITS];
    logic [CHANNEL_BITS-1:0] bright  [0:QUO_BITS];

    assign busy = 1'b0;

    rth_front #(
        .CHANNEL_BITS(CHANNEL_BITS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (start && !busy),
        .i_pixel  (i_pixel),
        .o_valid  (vld[0]),
        .o_hue_num(hue_rem[0]),
        .o_hue_div(hue_div[0]),
        .o_sat_num(sat_rem[0]),
        .o_sat_div(sat_div[0]),
        .o_bright (bright[0])
    );

    assign hue_quo[0] = '0;
    assign sat_quo[0] = '0;

    for (genvar k = 0; k < QUO_BITS; k++) begin : g_cell
        rth_div_cell #(
            .CHANNEL_BITS(CHANNEL_BITS),
            .BIT_POS     (QUO_BITS - 1 - k)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_valid  (vld[k]),
            .i_hue_rem(hue_rem[k]),
            .i_hue_div(hue_div[k]),
            .i_hue_quo(hue_quo[k]),
            .i_sat_rem(sat_rem[k]),
            .i_sat_div(sat_div[k]),
            .i_sat_quo(sat_quo[k]),
            .i_bright (bright[k]),
            .o_valid  (vld[k+1]),
            .o_hue_rem(hue_rem[k+1]),
            .o_hue_div(hue_div[k+1]),
            .o_hue_quo(hue_quo[k+1]),
            .o_sat_rem(sat_rem[k+1]),
            .o_sat_div(sat_div[k+1]),
            .o_sat_quo(sat_quo[k+1]),
            .o_bright (bright[k+1])
        );
    end

    assign o_valid             = vld[QUO_BITS];
    assign o_result.hue        = hue_quo[QUO_BITS][HUE_BITS-1:0];
    assign o_result.saturation = sat_quo[QUO_BITS][SAT_BITS-1:0];
    assign o_result.brightness = CHAN_PORT_BITS'(bright[QUO_BITS]);

`ifndef NO_ASSERTIONS
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |-> ##11 o_valid)
        else $error("accepted item did not come out after the pipeline latency");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, 11))
        else $error("result without a matching accepted item");

    a_hue_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (hue_quo[QUO_BITS] < QUO_BITS'(HUE_WRAP)))
        else $error("hue quotient out of range");

    a_sat_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (sat_quo[QUO_BITS] <= QUO_BITS'(SAT_FULL)))
        else $error("saturation quotient out of range");
`endif

endmodule

// ----- sim/rgb_to_hsv_tb.sv -----
`timescale 1ns / 100ps

module rgb_to_hsv_tb;

    import rth_pkg::*;

    localparam int unsigned CHANNEL_BITS = 16;
    localparam int          IDLE_LIMIT   = 2000;
    localparam int          RESULT_WAIT  = 30;

    logic  i_clk;
    logic  i_rst_n;
    logic  start;
    logic  busy;
    t_rgb  pixel_in;
    logic  o_valid;
    t_hsv  o_result;

    t_hsv  hsv_expected[$];
    int    mismatch_count;
    int    idle_cycles_seen;

    rgb_to_hsv #(
        .CHANNEL_BITS(CHANNEL_BITS)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_pixel (pixel_in),
        .o_valid (o_valid),
        .o_result(o_result)
    );

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    function automatic t_hsv predict_hsv(input t_rgb px);
        longint  mask;
        longint  r;
        longint  g;
        longint  b;
        longint  mx;
        longint  mn;
        longint  diff;
        longint  offset;
        longint  span;
        longint  num;
        longint  hue;
        longint  sat;
        t_sector sector;
        t_hsv    res;
        mask = (longint'(1) << CHANNEL_BITS) - 1;
        r = longint'(px.red) & mask;
        g = longint'(px.green) & mask;
        b = longint'(px.blue) & mask;
        hue = 0;
        sat = 0;
        if (r >= g && r >= b) begin
            sector = SEC_RED;
            mx = r;
            mn = (g < b) ? g : b;
            diff = g - b;
        end else if (g >= b) begin
            sector = SEC_GREEN;
            mx = g;
            mn = (r < b) ? r : b;
            diff = b - r;
        end else begin
            sector = SEC_BLUE;
            mx = b;
            mn = (r < g) ? r : g;
            diff = r - g;
        end
        case (sector)
            SEC_GREEN: offset = 2;
            SEC_BLUE:  offset = 4;
            default:   offset = 0;
        endcase
        if (mx != mn) begin
            span = mx - mn;
            num = 60 * (offset * span + diff);
            if (num < 0) begin
                num = num + HUE_WRAP * span;
            end
            hue = num / span;
            if (hue >= HUE_WRAP) begin
                hue = hue - HUE_WRAP;
            end
            sat = (SAT_FULL * span) / mx;
        end
        res.hue        = hue[HUE_BITS-1:0];
        res.saturation = sat[SAT_BITS-1:0];
        res.brightness = mx[CHAN_PORT_BITS-1:0];
        return res;
    endfunction

    function automatic t_rgb random_pixel();
        t_rgb             px;
        logic [15:0]      base;
        int               kind;
        kind = $urandom_range(0, 9);
        px.red   = 16'($urandom);
        px.green = 16'($urandom);
        px.blue  = 16'($urandom);
        base     = 16'($urandom);
        case (kind)
            0: begin
                px.green = px.red;
                px.blue  = px.red;
            end
            1: px.green = px.red;
            2: px.blue  = px.red;
            3: px.blue  = px.green;
            4: begin
                px.red   = 16'($urandom_range(0, 255));
                px.green = 16'($urandom_range(0, 255));
                px.blue  = 16'($urandom_range(0, 255));
            end
            5: begin
                px.red   = base;
                px.green = base ^ 16'($urandom_range(0, 3));
                px.blue  = base ^ 16'($urandom_range(0, 3));
            end
            default: ;
        endcase
        return px;
    endfunction

    // Both sides are observed here so that an item is queued before any
    // result of the same edge is checked.
    always @(posedge i_clk) begin
        t_hsv exp_hsv;
        if (i_rst_n && start && !busy) begin
            hsv_expected.push_back(predict_hsv(pixel_in));
        end
        if (i_rst_n && o_valid) begin
            if (hsv_expected.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display("unexpected result: hue %0d sat %0d value %0d",
                             o_result.hue, o_result.saturation, o_result.brightness);
                end
            end else begin
                exp_hsv = hsv_expected.pop_front();
                if (o_result.hue !== exp_hsv.hue
                        || o_result.saturation !== exp_hsv.saturation
                        || o_result.brightness !== exp_hsv.brightness) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display({"mismatch: expected hue %0d sat %0d value %0d, ",
                                  "got hue %0d sat %0d value %0d"},
                                 exp_hsv.hue, exp_hsv.saturation, exp_hsv.brightness,
                                 o_result.hue, o_result.saturation, o_result.brightness);
                    end
                end
            end
        end
        if ((start && !busy) || o_valid) begin
            idle_cycles_seen = 0;
        end else begin
            idle_cycles_seen++;
        end
        if (idle_cycles_seen >= IDLE_LIMIT) begin
            $display("rgb_to_hsv_tb: FAIL");
            $finish;
        end
    end

    task automatic send_pixel(input t_rgb px);
        @(negedge i_clk);
        start    <= 1'b1;
        pixel_in <= px;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic pause_sender(input int cycles);
        @(negedge i_clk);
        start <= 1'b0;
        repeat (cycles - 1) @(negedge i_clk);
    endtask

    task automatic wait_all_results();
        pause_sender(1);
        while (hsv_expected.size() != 0) @(posedge i_clk);
    endtask

    task automatic send_rgb(input logic [15:0] r, input logic [15:0] g,
                            input logic [15:0] b);
        t_rgb px;
        px.red   = r;
        px.green = g;
        px.blue  = b;
        send_pixel(px);
    endtask

    task automatic test_directed();
        send_rgb(16'h0000, 16'h0000, 16'h0000);
        send_rgb(16'hffff, 16'hffff, 16'hffff);
        send_rgb(16'h5a5a, 16'h5a5a, 16'h5a5a);
        send_rgb(16'hffff, 16'h0000, 16'h0000);
        send_rgb(16'h0000, 16'hffff, 16'h0000);
        send_rgb(16'h0000, 16'h0000, 16'hffff);
        send_rgb(16'h0001, 16'h0000, 16'h0000);
        send_rgb(16'hffff, 16'h0000, 16'h0001);
        send_rgb(16'd100, 16'd0, 16'd50);
        send_rgb(16'hffff, 16'hffff, 16'h0000);
        send_rgb(16'h0000, 16'hffff, 16'hffff);
        send_rgb(16'hffff, 16'h0000, 16'hffff);
        send_rgb(16'h8000, 16'h8000, 16'h1234);
        send_rgb(16'h8000, 16'h1234, 16'h8000);
        send_rgb(16'h1234, 16'h8000, 16'h8000);
        send_rgb(16'hffff, 16'hfffe, 16'hfffe);
        send_rgb(16'hfffe, 16'hffff, 16'hfffe);
        send_rgb(16'hfffe, 16'hfffe, 16'hffff);
        send_rgb(16'hffff, 16'h0001, 16'hfffe);
        send_rgb(16'h0001, 16'hfffe, 16'hffff);
        send_rgb(16'haaaa, 16'h5555, 16'h0000);
        send_rgb(16'h5555, 16'h0000, 16'haaaa);
    endtask

    task automatic test_random_with_gaps(input int count);
        bit gaps_on;
        gaps_on = 1'b1;
        for (int i = 0; i < count; i++) begin
            if (i % 40 == 0) begin
                gaps_on = ($urandom_range(0, 2) != 0);
            end
            send_pixel(random_pixel());
            if (gaps_on && $urandom_range(0, 2) == 0) begin
                pause_sender($urandom_range(1, 5));
            end
        end
    endtask

    task automatic test_back_to_back(input int count);
        for (int i = 0; i < count; i++) begin
            send_pixel(random_pixel());
        end
    endtask

    initial begin
        mismatch_count   = 0;
        idle_cycles_seen = 0;
        i_rst_n  = 1'b0;
        start    = 1'b0;
        pixel_in = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        wait_all_results();
        test_random_with_gaps(430);
        wait_all_results();
        test_back_to_back(150);

        @(negedge i_clk);
        start <= 1'b0;
        while (hsv_expected.size() != 0) @(posedge i_clk);
        repeat (RESULT_WAIT) @(posedge i_clk);
        if (mismatch_count == 0 && hsv_expected.size() == 0) begin
            $display("rgb_to_hsv_tb: PASS");
        end else begin
            $display("rgb_to_hsv_tb: FAIL");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
hdl/rth_pkg.sv
hdl/rth_front.sv
hdl/rth_div_cell.sv
hdl/rgb_to_hsv.sv
sim/rgb_to_hsv_tb.sv
